// ===== rtl/crra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crop-and-rotate read address package
// Shared widths, codes, configuration type and inter-stage bundles.
// ----------------------------------------------------------------------------
package crra_pkg;

    localparam int COORD_W        = 13;
    localparam int SIZE_W         = 14;
    localparam int SC_W           = 16;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int STRIDE_W       = 16;
    localparam int PROD_W         = COORD_W + STRIDE_W;
    localparam int ADDR_W         = 29;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int MAX_ROW_LENGTH = 8192;
    localparam int PIXEL_STRIDE   = 1;
    localparam int PLANE_LIMIT    = 8192;

    typedef logic [COORD_W-1:0]         t_coord;
    typedef logic [SIZE_W-1:0]          t_size;
    typedef logic signed [SC_W-1:0]     t_scoord;
    typedef logic [STRIDE_W-1:0]        t_stride;
    typedef logic [ADDR_W-1:0]          t_addr;

    typedef enum logic [1:0] {
        ROT_0,
        ROT_90,
        ROT_180,
        ROT_270
    } t_rot;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CROP_LEFT,
        CFG_CROP_TOP,
        CFG_CROP_RIGHT,
        CFG_CROP_BOTTOM,
        CFG_ROTATION,
        CFG_ROW_STRIDE,
        CFG_PLANE_WIDTH,
        CFG_PLANE_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        t_coord  crop_left;
        t_coord  crop_top;
        t_size   crop_right;
        t_size   crop_bottom;
        t_rot    rotation;
        t_stride row_stride;
        t_size   plane_width;
        t_size   plane_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        crop_left:    '0,
        crop_top:     '0,
        crop_right:   t_size'(1),
        crop_bottom:  t_size'(1),
        rotation:     ROT_0,
        row_stride:   '0,
        plane_width:  '0,
        plane_height: '0
    };

    // Input coordinates after the crop, output-size and row-clamp stages.
    typedef struct packed {
        t_coord  ox;
        t_coord  y;
        t_scoord owm1;
        t_scoord xl;
        t_scoord xh;
        t_scoord yl;
        t_scoord yh;
        t_coord  pwm1;
        t_coord  phm1;
        logic    empty;
    } t_geom;

    // Line end points clamped into the plane.
    typedef struct packed {
        t_coord ox;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        logic   empty;
    } t_line;

    // Source sample position.
    typedef struct packed {
        t_coord px;
        t_coord py;
        logic   empty;
    } t_pix;

    // Final result beat.
    typedef struct packed {
        t_coord src_x;
        t_coord src_y;
        t_addr  src_address;
        logic   plane_empty;
    } t_result;

endpackage

// ===== rtl/crra_geom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crop geometry stages
// Orders the crop edges, derives the rotated output size and clamps the row
// and the row length over three pipeline stages.
// ----------------------------------------------------------------------------
module crra_geom (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  crra_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  crra_pkg::t_coord i_out_x,
    input  crra_pkg::t_coord i_out_y,
    output logic            o_valid,
    input  logic            i_ready,
    output crra_pkg::t_geom o_data
);
    import crra_pkg::*;

    typedef struct packed {
        t_coord  ox;
        t_coord  oy;
        t_scoord xl;
        t_scoord xh;
        t_scoord yl;
        t_scoord yh;
        t_coord  pwm1;
        t_coord  phm1;
        logic    empty;
    } t_crop;

    typedef struct packed {
        t_crop   c;
        t_scoord wm1;
        t_scoord hm1;
    } t_size_st;

    logic     r_vld1, r_vld2, r_vld3;
    logic     rdy1, rdy2, rdy3;
    t_crop    r_s1, n_s1;
    t_size_st r_s2, n_s2;
    t_geom    r_s3, n_s3;

    t_scoord  left_s, top_s, right_s, bottom_s;
    t_scoord  span_x, span_y, oy_s, lim_s, pwm1_s;

    assign rdy3    = !r_vld3 || i_ready;
    assign rdy2    = !r_vld2 || rdy3;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_vld3;
    assign o_data  = r_s3;

    always_comb begin
        left_s   = t_scoord'(SC_W'(i_cfg.crop_left));
        top_s    = t_scoord'(SC_W'(i_cfg.crop_top));
        right_s  = t_scoord'(SC_W'(i_cfg.crop_right)) - t_scoord'(1);
        bottom_s = t_scoord'(SC_W'(i_cfg.crop_bottom)) - t_scoord'(1);
        n_s1.ox  = i_out_x;
        n_s1.oy  = i_out_y;
        n_s1.xl  = (left_s < right_s) ? left_s : right_s;
        n_s1.xh  = (left_s < right_s) ? right_s : left_s;
        n_s1.yl  = (top_s < bottom_s) ? top_s : bottom_s;
        n_s1.yh  = (top_s < bottom_s) ? bottom_s : top_s;
        n_s1.pwm1 = (i_cfg.plane_width > t_size'(PLANE_LIMIT)) ? t_coord'(PLANE_LIMIT - 1)
                                                              : t_coord'(i_cfg.plane_width - t_size'(1));
        n_s1.phm1 = (i_cfg.plane_height > t_size'(PLANE_LIMIT)) ? t_coord'(PLANE_LIMIT - 1)
                                                                : t_coord'(i_cfg.plane_height - t_size'(1));
        n_s1.empty = (i_cfg.plane_width == '0) || (i_cfg.plane_height == '0);
    end

    always_comb begin
        span_x = r_s1.xh - r_s1.xl;
        span_y = r_s1.yh - r_s1.yl;
        n_s2.c = r_s1;
        unique case (i_cfg.rotation)
            ROT_90, ROT_270: begin
                n_s2.wm1 = span_y;
                n_s2.hm1 = span_x;
            end
            ROT_0, ROT_180: begin
                n_s2.wm1 = span_x;
                n_s2.hm1 = span_y;
            end
        endcase
    end

    always_comb begin
        oy_s   = t_scoord'(SC_W'(r_s2.c.oy));
        pwm1_s = t_scoord'(SC_W'(r_s2.c.pwm1));
        lim_s  = (r_s2.wm1 < pwm1_s) ? r_s2.wm1 : pwm1_s;
        n_s3.ox    = r_s2.c.ox;
        n_s3.y     = (oy_s < r_s2.hm1) ? r_s2.c.oy : t_coord'(r_s2.hm1);
        n_s3.owm1  = (lim_s < t_scoord'(MAX_ROW_LENGTH - 1)) ? lim_s
                                                            : t_scoord'(MAX_ROW_LENGTH - 1);
        n_s3.xl    = r_s2.c.xl;
        n_s3.xh    = r_s2.c.xh;
        n_s3.yl    = r_s2.c.yl;
        n_s3.yh    = r_s2.c.yh;
        n_s3.pwm1  = r_s2.c.pwm1;
        n_s3.phm1  = r_s2.c.phm1;
        n_s3.empty = r_s2.c.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_s1 <= n_s1;
        if (rdy2) r_s2 <= n_s2;
        if (rdy3) r_s3 <= n_s3;
    end

endmodule

// ===== rtl/crra_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line mapping stages
// Maps the first and last pixel of the output row through the rotation and
// clamps both end points into the plane.
// ----------------------------------------------------------------------------
module crra_map (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  crra_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  crra_pkg::t_geom i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output crra_pkg::t_line o_data
);
    import crra_pkg::*;

    typedef struct packed {
        t_coord  ox;
        t_scoord sx;
        t_scoord sy;
        t_scoord ex;
        t_scoord ey;
        t_coord  pwm1;
        t_coord  phm1;
        logic    empty;
    } t_ends;

    function automatic t_coord clamp_pos(t_scoord v, t_coord hi);
        t_scoord hi_s;
        hi_s = t_scoord'(SC_W'(hi));
        if (v < t_scoord'(0)) begin
            return '0;
        end else if (v > hi_s) begin
            return hi;
        end
        return t_coord'(v);
    endfunction

    logic    r_vld1, r_vld2;
    logic    rdy1, rdy2;
    t_ends   r_s1, n_s1;
    t_line   r_s2, n_s2;
    t_scoord y_s;

    assign rdy2    = !r_vld2 || i_ready;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_vld2;
    assign o_data  = r_s2;

    always_comb begin
        y_s        = t_scoord'(SC_W'(i_data.y));
        n_s1.ox    = i_data.ox;
        n_s1.pwm1  = i_data.pwm1;
        n_s1.phm1  = i_data.phm1;
        n_s1.empty = i_data.empty;
        unique case (i_cfg.rotation)
            ROT_0: begin
                n_s1.sx = i_data.xl;
                n_s1.sy = y_s + i_data.yl;
                n_s1.ex = i_data.xl + i_data.owm1;
                n_s1.ey = y_s + i_data.yl;
            end
            ROT_90: begin
                n_s1.sx = i_data.xh - y_s;
                n_s1.sy = i_data.yl;
                n_s1.ex = i_data.xh - y_s;
                n_s1.ey = i_data.yl + i_data.owm1;
            end
            ROT_180: begin
                n_s1.sx = i_data.xh;
                n_s1.sy = i_data.yh - y_s;
                n_s1.ex = i_data.xh - i_data.owm1;
                n_s1.ey = i_data.yh - y_s;
            end
            ROT_270: begin
                n_s1.sx = y_s + i_data.xl;
                n_s1.sy = i_data.yh;
                n_s1.ex = y_s + i_data.xl;
                n_s1.ey = i_data.yh - i_data.owm1;
            end
        endcase
    end

    always_comb begin
        n_s2.ox    = r_s1.ox;
        n_s2.sx    = clamp_pos(r_s1.sx, r_s1.pwm1);
        n_s2.sy    = clamp_pos(r_s1.sy, r_s1.phm1);
        n_s2.ex    = clamp_pos(r_s1.ex, r_s1.pwm1);
        n_s2.ey    = clamp_pos(r_s1.ey, r_s1.phm1);
        n_s2.empty = r_s1.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_s1 <= n_s1;
        if (rdy2) r_s2 <= n_s2;
    end

endmodule

// ===== rtl/crra_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line walk stages
// Measures the clamped line and steps along it by the output column, holding
// the last sample once the column runs past the end.
// ----------------------------------------------------------------------------
module crra_walk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  crra_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  crra_pkg::t_line i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output crra_pkg::t_pix  o_data
);
    import crra_pkg::*;

    typedef struct packed {
        t_coord ox;
        t_coord sx;
        t_coord sy;
        logic   horiz;
        logic   neg;
        t_coord steps;
        logic   empty;
    } t_span;

    logic                      r_vld1, r_vld2;
    logic                      rdy1, rdy2;
    t_span                     r_s1, n_s1;
    t_pix                      r_s2, n_s2;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  mag;
    t_coord                    k, base, along;

    assign rdy2    = !r_vld2 || i_ready;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_vld2;
    assign o_data  = r_s2;

    always_comb begin
        n_s1.horiz = (i_cfg.rotation == ROT_0) || (i_cfg.rotation == ROT_180);
        if (n_s1.horiz) begin
            diff = $signed({1'b0, i_data.ex}) - $signed({1'b0, i_data.sx});
        end else begin
            diff = $signed({1'b0, i_data.ey}) - $signed({1'b0, i_data.sy});
        end
        mag        = diff[DIFF_W-1] ? -diff : diff;
        n_s1.neg   = diff[DIFF_W-1];
        n_s1.steps = t_coord'(mag);
        n_s1.ox    = i_data.ox;
        n_s1.sx    = i_data.sx;
        n_s1.sy    = i_data.sy;
        n_s1.empty = i_data.empty;
    end

    always_comb begin
        k     = (r_s1.ox < r_s1.steps) ? r_s1.ox : r_s1.steps;
        base  = r_s1.horiz ? r_s1.sx : r_s1.sy;
        along = r_s1.neg ? (base - k) : (base + k);
        n_s2.px    = r_s1.horiz ? along : r_s1.sx;
        n_s2.py    = r_s1.horiz ? r_s1.sy : along;
        n_s2.empty = r_s1.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_s1 <= n_s1;
        if (rdy2) r_s2 <= n_s2;
    end

endmodule

// ===== rtl/crra_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address stages
// Multiplies the source row by the row stride, adds the column offset and
// holds the result beat in the output register; an empty plane gives zeros.
// ----------------------------------------------------------------------------
module crra_addr (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  crra_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  crra_pkg::t_pix    i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output crra_pkg::t_result o_data
);
    import crra_pkg::*;

    typedef struct packed {
        t_coord            px;
        t_coord            py;
        logic [PROD_W-1:0] prod;
        logic              empty;
    } t_mul;

    logic    r_vld1, r_vld2;
    logic    rdy1, rdy2;
    t_mul    r_s1, n_s1;
    t_result r_s2, n_s2;
    t_addr   col_off;

    assign rdy2    = !r_vld2 || i_ready;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_vld2;
    assign o_data  = r_s2;

    always_comb begin
        n_s1.px    = i_data.px;
        n_s1.py    = i_data.py;
        n_s1.prod  = PROD_W'(i_data.py) * PROD_W'(i_cfg.row_stride);
        n_s1.empty = i_data.empty;
    end

    always_comb begin
        col_off = t_addr'(r_s1.px) * t_addr'(PIXEL_STRIDE);
        if (r_s1.empty) begin
            n_s2.src_x       = '0;
            n_s2.src_y       = '0;
            n_s2.src_address = '0;
        end else begin
            n_s2.src_x       = r_s1.px;
            n_s2.src_y       = r_s1.py;
            n_s2.src_address = t_addr'(r_s1.prod) + col_off;
        end
        n_s2.plane_empty = r_s1.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_s1 <= n_s1;
        if (rdy2) r_s2 <= n_s2;
    end

endmodule

// ===== rtl/crop_rotate_read_address_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crop-and-rotate read address generator
// Maps an output pixel of a cropped and rotated image to its source sample.
// ----------------------------------------------------------------------------
// Usage: the configuration registers (crop edges, rotation, row stride and
// plane size) are written through the write port while no beat is in
// flight. Each input beat carries one output coordinate; each output beat
// carries the source column, source row, byte address and the empty flag.
// Both channels use valid/ready and a beat moves when both are high.
// The datapath is nine register stages: crop ordering, output size, row
// clamp, rotation map, plane clamp, line measure, line step, stride
// multiply and address add. One beat is taken per cycle unless a stall at
// the receiver has filled every stage.
// Reset restores the register defaults and empties every stage.
// When the receiver stalls, each stage holds its beat and bubbles ahead of
// it close up; the input ready drops only once all nine stages are full.
// ----------------------------------------------------------------------------
module crop_rotate_read_address_gen (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [crra_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [crra_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  crra_pkg::t_coord                      i_out_x,
    input  crra_pkg::t_coord                      i_out_y,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output crra_pkg::t_coord                      o_src_x,
    output crra_pkg::t_coord                      o_src_y,
    output crra_pkg::t_addr                       o_src_address,
    output logic                                  o_plane_empty
);
    import crra_pkg::*;

    t_cfg    r_cfg;
    logic    geom_vld, geom_rdy, map_vld, map_rdy, walk_vld, walk_rdy;
    t_geom   geom_data;
    t_line   map_data;
    t_pix    walk_data;
    t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CROP_LEFT:    r_cfg.crop_left    <= i_cfg_data[COORD_W-1:0];
                CFG_CROP_TOP:     r_cfg.crop_top     <= i_cfg_data[COORD_W-1:0];
                CFG_CROP_RIGHT:   r_cfg.crop_right   <= i_cfg_data[SIZE_W-1:0];
                CFG_CROP_BOTTOM:  r_cfg.crop_bottom  <= i_cfg_data[SIZE_W-1:0];
                CFG_ROTATION:     r_cfg.rotation     <= t_rot'(i_cfg_data[$bits(t_rot)-1:0]);
                CFG_ROW_STRIDE:   r_cfg.row_stride   <= i_cfg_data[STRIDE_W-1:0];
                CFG_PLANE_WIDTH:  r_cfg.plane_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_PLANE_HEIGHT: r_cfg.plane_height <= i_cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    crra_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_out_x (i_out_x),
        .i_out_y (i_out_y),
        .o_valid (geom_vld),
        .i_ready (geom_rdy),
        .o_data  (geom_data)
    );

    crra_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (geom_vld),
        .o_ready (geom_rdy),
        .i_data  (geom_data),
        .o_valid (map_vld),
        .i_ready (map_rdy),
        .o_data  (map_data)
    );

    crra_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (map_vld),
        .o_ready (map_rdy),
        .i_data  (map_data),
        .o_valid (walk_vld),
        .i_ready (walk_rdy),
        .o_data  (walk_data)
    );

    crra_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (walk_vld),
        .o_ready (walk_rdy),
        .i_data  (walk_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res)
    );

    assign o_src_x       = res.src_x;
    assign o_src_y       = res.src_y;
    assign o_src_address = res.src_address;
    assign o_plane_empty = res.plane_empty;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_plane_empty) |->
            ((o_src_x == '0) && (o_src_y == '0) && (o_src_address == '0)))
        else $error("empty-plane beat carries a nonzero position or address");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while the output side is free");

    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output beat valid right after reset");

endmodule
